/* rtl/srrw_pkg.sv */
// Shared types and constants of the selective-repeat receive window.
// Used by the channel interfaces and the top level; depends on nothing.
package srrw_pkg;

  localparam int DEF_WINDOW_SLOTS = 32;
  localparam int DEF_SEQ_BITS     = 16;
  localparam int DEF_PAYLOAD_BITS = 32;

  localparam logic OP_HANDSHAKE = 1'b0;
  localparam logic OP_DATA      = 1'b1;

  localparam logic KIND_ACK      = 1'b0;
  localparam logic KIND_DELIVERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_ACK,
    ST_RD,
    ST_EMIT
  } state_t;

endpackage

/* rtl/srrw_pkt_if.sv */
// Packet input channel: valid/ready handshake with operation, sequence and payload.
// Depends on srrw_pkg for default widths.
interface srrw_pkt_if import srrw_pkg::*; #(
  parameter int SEQ_BITS     = DEF_SEQ_BITS,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
);
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [SEQ_BITS-1:0]     seq_number;
  logic [PAYLOAD_BITS-1:0] payload_handle;

  modport source (output valid, operation, seq_number, payload_handle, input ready);
  modport sink (input valid, operation, seq_number, payload_handle, output ready);
endinterface

/* rtl/srrw_res_if.sv */
// Result output channel: valid/ready handshake with acknowledgement or delivery fields.
// Depends on srrw_pkg for default widths.
interface srrw_res_if import srrw_pkg::*; #(
  parameter int SEQ_BITS     = DEF_SEQ_BITS,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
);
  logic                    valid;
  logic                    ready;
  logic                    result_kind;
  logic [SEQ_BITS-1:0]     ack_number;
  logic [SEQ_BITS-1:0]     reply_seq;
  logic                    syn_flag;
  logic [PAYLOAD_BITS-1:0] delivered_payload;
  logic                    last_of_run;

  modport source (output valid, result_kind, ack_number, reply_seq, syn_flag,
                  delivered_payload, last_of_run, input ready);
  modport sink (input valid, result_kind, ack_number, reply_seq, syn_flag,
                delivered_payload, last_of_run, output ready);
endinterface

/* rtl/selective_repeat_receive_window_top.sv */
// Receiver window of a selective-repeat link. One packet transaction is taken at a time.
// A packet that is dropped, or that only causes an acknowledgement while the output is
// free, returns to idle from ST_DECIDE; the opening handshake passes through ST_ACK. An
// in-order packet is stored, then each delivered payload is a payload memory read, then
// the output register load, and the closing acknowledgement is the read that finds the
// next slot empty, then the output register load. Any output stall holds the transaction
// in its state. Depends on srrw_pkg, srrw_pkt_if and srrw_res_if.
module selective_repeat_receive_window_top import srrw_pkg::*; #(
  parameter int WINDOW_SLOTS = DEF_WINDOW_SLOTS,
  parameter int SEQ_BITS     = DEF_SEQ_BITS,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SEQ_BITS-1:0] cfg_data,
  srrw_pkt_if.sink            pkt,
  srrw_res_if.source          res
);

  localparam int  SLOT_BITS  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam logic [SEQ_BITS:0]  WIN_WIDE  = (SEQ_BITS + 1)'(WINDOW_SLOTS);
  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(WINDOW_SLOTS - 1);

  state_t state, state_next;

  logic [SEQ_BITS-1:0]     initial_reply_seq;
  logic                    opened;
  logic [SEQ_BITS-1:0]     last_acked;
  logic [SEQ_BITS-1:0]     reply_counter;
  logic                    syn_state;
  logic [WINDOW_SLOTS-1:0] slot_valid;
  logic [SLOT_BITS-1:0]    base_slot;
  logic [SLOT_BITS-1:0]    cur_slot;

  logic                    pkt_op;
  logic [SEQ_BITS-1:0]     pkt_seq;
  logic [PAYLOAD_BITS-1:0] pkt_payload;

  logic [PAYLOAD_BITS-1:0] slot_mem [WINDOW_SLOTS];
  logic [PAYLOAD_BITS-1:0] rd_data;

  logic                    out_valid;
  logic                    out_kind;
  logic [SEQ_BITS-1:0]     out_ack;
  logic [SEQ_BITS-1:0]     out_reply;
  logic                    out_syn;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic                    out_last;

  logic                    out_free;
  logic [SEQ_BITS-1:0]     seq_dist;
  logic                    out_of_win;
  logic [SEQ_BITS:0]       slot_sum;
  logic [SEQ_BITS:0]       slot_wrap;
  logic [SLOT_BITS-1:0]    pkt_slot;
  logic [SLOT_BITS-1:0]    cur_slot_inc;
  logic [SLOT_BITS-1:0]    base_slot_inc;

  logic do_open;
  logic do_store;
  logic emit_ack;
  logic emit_dlv;

  assign out_free   = !out_valid || res.ready;
  assign pkt.ready  = (state == ST_IDLE);
  assign seq_dist   = pkt_seq - last_acked;
  assign out_of_win = {1'b0, seq_dist} > WIN_WIDE;
  assign slot_sum   = (SEQ_BITS + 1)'(base_slot) + {1'b0, seq_dist};
  assign slot_wrap  = (slot_sum >= WIN_WIDE) ? slot_sum - WIN_WIDE : slot_sum;
  assign pkt_slot   = slot_wrap[SLOT_BITS-1:0];
  assign cur_slot_inc  = (cur_slot == LAST_SLOT) ? '0 : cur_slot + 1'b1;
  assign base_slot_inc = (base_slot == LAST_SLOT) ? '0 : base_slot + 1'b1;

  always_comb begin
    state_next = state;
    do_open    = 1'b0;
    do_store   = 1'b0;
    emit_ack   = 1'b0;
    emit_dlv   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (pkt.valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (pkt_op == OP_HANDSHAKE && !opened) begin
          do_open    = 1'b1;
          state_next = ST_ACK;
        end else if (pkt_op == OP_HANDSHAKE || (opened && !out_of_win && seq_dist != 1)) begin
          if (pkt_op == OP_DATA && seq_dist != 0) begin
            do_store = !slot_valid[pkt_slot];
          end
          emit_ack   = out_free;
          state_next = out_free ? ST_IDLE : ST_ACK;
        end else if (opened && !out_of_win) begin
          do_store   = 1'b1;
          state_next = ST_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          emit_ack   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_RD: begin
        state_next = slot_valid[cur_slot] ? ST_EMIT : ST_ACK;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit_dlv   = 1'b1;
          state_next = ST_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_store) begin
      slot_mem[pkt_slot] <= pkt_payload;
    end
    rd_data <= slot_mem[cur_slot];
  end

  always_ff @(posedge clk) begin
    if (pkt.valid && pkt.ready) begin
      pkt_op      <= pkt.operation;
      pkt_seq     <= pkt.seq_number;
      pkt_payload <= pkt.payload_handle;
    end
    if (do_store) begin
      cur_slot <= pkt_slot;
    end else if (emit_dlv) begin
      cur_slot <= cur_slot_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_reply_seq <= '0;
      opened            <= 1'b0;
      last_acked        <= '0;
      reply_counter     <= '0;
      syn_state         <= 1'b0;
      slot_valid        <= '0;
      base_slot         <= '0;
    end else begin
      if (cfg_we) begin
        initial_reply_seq <= cfg_data;
      end
      if (do_open) begin
        opened        <= 1'b1;
        last_acked    <= pkt_seq;
        reply_counter <= initial_reply_seq;
        syn_state     <= 1'b1;
        base_slot     <= '0;
      end
      if (do_store) begin
        slot_valid[pkt_slot] <= 1'b1;
      end
      if (emit_dlv) begin
        syn_state            <= 1'b0;
        reply_counter        <= reply_counter + 1'b1;
        last_acked           <= last_acked + 1'b1;
        slot_valid[cur_slot] <= 1'b0;
        base_slot            <= base_slot_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ack || emit_dlv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ack) begin
      out_kind    <= KIND_ACK;
      out_ack     <= last_acked;
      out_reply   <= reply_counter;
      out_syn     <= syn_state;
      out_payload <= '0;
      out_last    <= 1'b1;
    end else if (emit_dlv) begin
      out_kind    <= KIND_DELIVERY;
      out_ack     <= last_acked + 1'b1;
      out_reply   <= reply_counter + 1'b1;
      out_syn     <= 1'b0;
      out_payload <= rd_data;
      out_last    <= 1'b0;
    end
  end

  assign res.valid             = out_valid;
  assign res.result_kind       = out_kind;
  assign res.ack_number        = out_ack;
  assign res.reply_seq         = out_reply;
  assign res.syn_flag          = out_syn;
  assign res.delivered_payload = out_payload;
  assign res.last_of_run       = out_last;

  a_emit_slot_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> slot_valid[cur_slot])
    else $error("Delivery pending on a slot that is not valid.");

  a_accept_decide: assert property (@(posedge clk) disable iff (rst)
    (pkt.valid && pkt.ready) |=> (state == ST_DECIDE))
    else $error("Accepted transaction was not decoded next.");

  a_delivery_opened: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.result_kind == KIND_DELIVERY) |-> opened)
    else $error("Delivery produced before the link was opened.");

  a_no_emit_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |-> !(emit_ack || emit_dlv))
    else $error("Output register overwritten while stalled.");

endmodule
